// ===== rtl/core/running_mean_stddev_goal_unit_assert.svh =====
// Assertion macros for the running mean and deviation unit.
// Needs signals clk and arst_n in the including scope.
`ifndef RUNNING_MEAN_STDDEV_GOAL_UNIT_ASSERT_SVH
`define RUNNING_MEAN_STDDEV_GOAL_UNIT_ASSERT_SVH

// antecedent implies consequent on the next clock
`define RMSG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmsg assertion failed");

// antecedent implies consequent on the same clock
`define RMSG_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmsg assertion failed");

`endif

// ===== rtl/core/rmsg_pkg.sv =====
// Shared types and constants of the running mean and deviation unit.
// No dependencies.
`timescale 1ns / 1ps
package rmsg_pkg;
	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 17;
	localparam int SUM_W    = 33;
	localparam int SQSUM_W  = 49;
	localparam int MUL_W    = 33;
	localparam int PROD_W   = 2 * MUL_W;

	localparam logic [15:0] GOAL_RESET = 16'd10;
	localparam logic [15:0] THR_RESET  = 16'sd1280;

	localparam logic [1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [1:0] CMD_START   = 2'd1;
	localparam logic [1:0] CMD_PREEMPT = 2'd2;

	localparam logic [1:0] OUTC_RUNNING   = 2'd0;
	localparam logic [1:0] OUTC_SUCCEEDED = 2'd1;
	localparam logic [1:0] OUTC_ABORTED   = 2'd2;

	localparam logic CFG_GOAL = 1'b0;
	localparam logic CFG_THR  = 1'b1;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_STOP, OP_LOAD, OP_ACC, OP_SQ, OP_MQ0, OP_MQ1,
		OP_MNN, OP_MTH, OP_DINIT_M, OP_DSTEP, OP_DINIT_V, OP_SINIT, OP_SSTEP, OP_FIN
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACC, ST_SQ, ST_MQ0, ST_MQ1, ST_MNN, ST_MTH, ST_DINIT_M,
		ST_DIV_M, ST_DINIT_V, ST_DIV_V, ST_SINIT, ST_SQRT, ST_FIN
	} st_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
	} dp_stat_t;
endpackage

// ===== rtl/core/running_mean_stddev_goal_unit.sv =====
// Top level of the running mean and standard deviation unit.
// Depends on rmsg_pkg, rmsg_ctrl and rmsg_dp.
//
// channel   dir  fields (low bit up)
// s_*       in   tuser: cmd[1:0]; tdata: sample_value[15:0]
// m_*       out  tdata: sample_index, sample_echo, running_mean, running_std_dev,
//                job_outcome
// cfg_*     in   cfg_index: register, cfg_data: value
//
// A start, preempt or ignored item is handled in idle. A sample of an active job
// runs from acceptance to the next acceptance through six multiply steps, two
// 64-step divisions and a 32-step root, each with a set-up step, and the final write.
// Reset clears the job, sums and handshakes and loads the register defaults.
// A finished result waits in the output register; the next item's work runs under a
// stall and holds only at the final write. Configuration is always ready.
`timescale 1ns / 1ps
module running_mean_stddev_goal_unit import rmsg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample_value[15:0]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // index[16:0] echo[32:17] mean[48:33] sd[64:49] outcome[66:65]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [COUNT_W-1:0]  o_index;
	logic [SAMPLE_W-1:0] o_echo;
	logic [15:0] o_mean, o_sd;
	logic [1:0]  o_outcome;

	assign cfg_ready = 1'b1;

	rmsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_cmd    (s_tuser),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.stat      (stat),
		.cmd       (cmd)
	);

	rmsg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_sample (s_tdata),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.o_index   (o_index),
		.o_echo    (o_echo),
		.o_mean    (o_mean),
		.o_sd      (o_sd),
		.o_outcome (o_outcome)
	);

	assign m_tdata = {5'b0, o_outcome, o_sd, o_mean, o_echo, o_index};
endmodule

// ===== rtl/core/rmsg_ctrl.sv =====
// Controller state machine: sequences accumulate, multiply, divide and root steps.
// Depends on rmsg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "running_mean_stddev_goal_unit_assert.svh"
module rmsg_ctrl import rmsg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic [1:0] in_cmd,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	st_t state_q, state_d;
	logic [5:0] ctr_q, ctr_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ctr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ctr_q       <= ctr_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctr_d       = ctr_q;
		cmd.op      = OP_NONE;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					priority if (in_cmd == CMD_START) begin
						cmd.op = OP_CLEAR;
					end else if (in_cmd == CMD_PREEMPT) begin
						cmd.op = OP_STOP;
					end else if (in_cmd == CMD_SAMPLE && stat.active) begin
						cmd.op  = OP_LOAD;
						state_d = ST_ACC;
					end else begin
						cmd.op = OP_NONE;
					end
				end
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.op  = OP_SQ;
				state_d = ST_MQ0;
			end
			ST_MQ0: begin
				cmd.op  = OP_MQ0;
				state_d = ST_MQ1;
			end
			ST_MQ1: begin
				cmd.op  = OP_MQ1;
				state_d = ST_MNN;
			end
			ST_MNN: begin
				cmd.op  = OP_MNN;
				state_d = ST_MTH;
			end
			ST_MTH: begin
				cmd.op  = OP_MTH;
				state_d = ST_DINIT_M;
			end
			ST_DINIT_M: begin
				cmd.op  = OP_DINIT_M;
				ctr_d   = 6'd63;
				state_d = ST_DIV_M;
			end
			ST_DIV_M: begin
				cmd.op = OP_DSTEP;
				ctr_d  = ctr_q - 6'd1;
				if (ctr_q == '0) state_d = ST_DINIT_V;
			end
			ST_DINIT_V: begin
				cmd.op  = OP_DINIT_V;
				ctr_d   = 6'd63;
				state_d = ST_DIV_V;
			end
			ST_DIV_V: begin
				cmd.op = OP_DSTEP;
				ctr_d  = ctr_q - 6'd1;
				if (ctr_q == '0) state_d = ST_SINIT;
			end
			ST_SINIT: begin
				cmd.op  = OP_SINIT;
				ctr_d   = 6'd31;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SSTEP;
				ctr_d  = ctr_q - 6'd1;
				if (ctr_q == '0) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_FIN;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	`RMSG_ASSERT_NEXT(a_sample_starts, in_valid && in_ready && in_cmd == CMD_SAMPLE && stat.active, state_q == ST_ACC)
	`RMSG_ASSERT_NEXT(a_fin_holds, state_q == ST_FIN && out_valid_q && !out_ready, state_q == ST_FIN && out_valid_q)
	`RMSG_ASSERT_NEXT(a_div_done, state_q == ST_DIV_M && ctr_q == '0, state_q == ST_DINIT_V)
	`RMSG_ASSERT_SAME(a_busy_no_accept, state_q != ST_IDLE, !in_ready)
endmodule

// ===== rtl/core/rmsg_dp.sv =====
// Datapath: job state, sums, shared multiplier, restoring divider, integer root.
// Depends on rmsg_pkg.
`timescale 1ns / 1ps
module rmsg_dp import rmsg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  dp_cmd_t       cmd,
	output dp_stat_t      stat,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic [15:0]   cfg_wdata,
	output logic [COUNT_W-1:0]  o_index,
	output logic [SAMPLE_W-1:0] o_echo,
	output logic [15:0]   o_mean,
	output logic [15:0]   o_sd,
	output logic [1:0]    o_outcome
);
	logic active_q;
	logic [15:0] goal_q, thr_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQSUM_W-1:0] sq_q;
	logic [SAMPLE_W-1:0] x_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [63:0] s2_q, nq_q, nn_q;
	logic [63:0] dq_q;
	logic [32:0] rem_q, dv_q;
	logic [15:0] mean_q;
	logic [63:0] rad_q;
	logic [34:0] srem_q;
	logic [31:0] root_q;

	logic signed [MUL_W-1:0] ma, mb;
	logic [31:0] abs_s;
	logic [33:0] dr;
	logic [34:0] sr, st;
	logic [63:0] q_abs;
	logic [COUNT_W-1:0] cnt_inc;

	assign abs_s = sum_q[SUM_W-1] ? 32'((~sum_q) + 33'd1) : sum_q[31:0];
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign dr = {rem_q, dq_q[63]};
	assign sr = {srem_q[32:0], rad_q[63:62]};
	assign st = {1'b0, root_q, 2'b01};
	assign q_abs = dq_q;

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.op)
			OP_ACC: begin
				ma = MUL_W'($signed(x_q));
				mb = MUL_W'($signed(x_q));
			end
			OP_SQ: begin
				ma = {1'b0, abs_s};
				mb = {1'b0, abs_s};
			end
			OP_MQ0: begin
				ma = {16'b0, cnt_q};
				mb = {1'b0, sq_q[31:0]};
			end
			OP_MQ1: begin
				ma = {16'b0, cnt_q};
				mb = {16'b0, sq_q[48:32]};
			end
			OP_MNN: begin
				ma = {16'b0, cnt_q};
				mb = {16'b0, cnt_q};
			end
			OP_MTH: begin
				ma = MUL_W'($signed(thr_q));
				mb = {16'b0, cnt_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			goal_q   <= GOAL_RESET;
			thr_q    <= THR_RESET;
			cnt_q    <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_GOAL) goal_q <= cfg_wdata;
				else thr_q <= cfg_wdata;
			end
			unique case (cmd.op)
				OP_CLEAR: begin
					active_q <= 1'b1;
					cnt_q    <= '0;
					sum_q    <= '0;
					sq_q     <= '0;
				end
				OP_STOP: active_q <= 1'b0;
				OP_ACC: begin
					cnt_q <= cnt_inc;
					sum_q <= sum_q + SUM_W'($signed(x_q));
				end
				OP_SQ: sq_q <= sq_q + SQSUM_W'(prod_q[47:0]);
				OP_FIN: if (cnt_q > {1'b0, goal_q}) active_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACC || cmd.op == OP_SQ || cmd.op == OP_MQ0 ||
		    cmd.op == OP_MQ1 || cmd.op == OP_MNN || cmd.op == OP_MTH)
			prod_q <= ma * mb;
		unique case (cmd.op)
			OP_LOAD: x_q <= in_sample;
			OP_MQ0:  s2_q <= prod_q[63:0];
			OP_MQ1:  nq_q <= prod_q[63:0];
			OP_MNN:  nq_q <= nq_q + {prod_q[31:0], 32'b0};
			OP_MTH:  nn_q <= prod_q[63:0];
			OP_DINIT_M: begin
				dq_q  <= {32'b0, abs_s};
				rem_q <= '0;
				dv_q  <= {16'b0, cnt_q};
			end
			OP_DSTEP: begin
				if (dr >= {1'b0, dv_q}) begin
					rem_q <= 33'(dr - {1'b0, dv_q});
					dq_q  <= {dq_q[62:0], 1'b1};
				end else begin
					rem_q <= dr[32:0];
					dq_q  <= {dq_q[62:0], 1'b0};
				end
			end
			OP_DINIT_V: begin
				if (sum_q[SUM_W-1])
					mean_q <= (q_abs > 64'd32768) ? 16'h8000 : 16'((~q_abs) + 64'd1);
				else
					mean_q <= (q_abs > 64'd32767) ? 16'h7fff : q_abs[15:0];
				dq_q  <= (nq_q > s2_q) ? nq_q - s2_q : 64'd0;
				rem_q <= '0;
				dv_q  <= nn_q[32:0];
			end
			OP_SINIT: begin
				rad_q  <= dq_q;
				srem_q <= '0;
				root_q <= '0;
			end
			OP_SSTEP: begin
				rad_q <= {rad_q[61:0], 2'b00};
				if (sr >= st) begin
					srem_q <= sr - st;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= sr;
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			OP_FIN: begin
				o_index <= cnt_q;
				o_echo  <= x_q;
				o_mean  <= mean_q;
				o_sd    <= (root_q > 32'd65535) ? 16'hffff : root_q[15:0];
				if (cnt_q > {1'b0, goal_q})
					o_outcome <= ($signed({{33{sum_q[SUM_W-1]}}, sum_q}) < prod_q) ?
						OUTC_ABORTED : OUTC_SUCCEEDED;
				else
					o_outcome <= OUTC_RUNNING;
			end
			default: ;
		endcase
	end

	assign stat.active = active_q;
endmodule
